>>> rtl/rt3d_pkg.sv
// ============================================================================
// rt3d_pkg: shared types and constants of the rigid transform unit
// Payload structs, mode codes, register indexes and fixed-point helpers.
// ============================================================================
package rt3d_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    // Mode codes carried by an input transfer.
    localparam logic [2:0] MODE_PT_LOCAL  = 3'd0;
    localparam logic [2:0] MODE_PT_WORLD  = 3'd1;
    localparam logic [2:0] MODE_DIR_LOCAL = 3'd2;
    localparam logic [2:0] MODE_DIR_WORLD = 3'd3;
    localparam logic [2:0] MODE_BOX_LOCAL = 3'd4;
    localparam logic [2:0] MODE_BOX_WORLD = 3'd5;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROT_W   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Y   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Z   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd6;

    typedef struct packed {
        logic [2:0]   mode;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
    } t_out_item;

    // Per-item control that travels with the lane data.
    typedef struct packed {
        logic world;
        logic point;
        logic box;
        logic zero;
    } t_ctl;

    // Rotation matrix, row major, Q2.30.
    typedef logic signed [8:0][31:0] t_matrix;

    // Round a 66-bit product by 30 bits (add half, arithmetic shift).
    // The result keeps every bit a 32 by 33 bit product can leave.
    function automatic logic signed [35:0] rnd30(input logic signed [65:0] p);
        logic signed [65:0] s;
        s = p + 66'sd536870912;
        return s[65:30];
    endfunction

    // Saturate to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -38'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

>>> rtl/rt3d_matrix.sv
// ============================================================================
// rt3d_matrix: quaternion to rotation matrix
// Registers the configuration and derives the Q2.30 matrix over two stages.
// ============================================================================
module rt3d_matrix (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rt3d_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rt3d_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output rt3d_pkg::t_matrix                o_mat,
    output logic signed [2:0][31:0]          o_shift
);
    import rt3d_pkg::*;

    logic signed [31:0] r_w, r_x, r_y, r_z;
    logic signed [2:0][31:0] r_shift;
    logic signed [8:0][35:0] r_prod;
    logic signed [8:0][35:0] n_prod;
    t_matrix r_mat;
    t_matrix n_mat;

    // Register file; user must write only while block is idle (not enforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w     <= 32'sh40000000;
            r_x     <= '0;
            r_y     <= '0;
            r_z     <= '0;
            r_shift <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROT_W:   r_w <= i_cfg_data;
                REG_ROT_X:   r_x <= i_cfg_data;
                REG_ROT_Y:   r_y <= i_cfg_data;
                REG_ROT_Z:   r_z <= i_cfg_data;
                REG_SHIFT_X: r_shift[0] <= i_cfg_data;
                REG_SHIFT_Y: r_shift[1] <= i_cfg_data;
                REG_SHIFT_Z: r_shift[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Nine quaternion products, each rounded to Q2.30.
    always_comb begin
        n_prod[0] = rnd30(66'(r_x * r_x));
        n_prod[1] = rnd30(66'(r_y * r_y));
        n_prod[2] = rnd30(66'(r_z * r_z));
        n_prod[3] = rnd30(66'(r_x * r_y));
        n_prod[4] = rnd30(66'(r_x * r_z));
        n_prod[5] = rnd30(66'(r_y * r_z));
        n_prod[6] = rnd30(66'(r_w * r_x));
        n_prod[7] = rnd30(66'(r_w * r_y));
        n_prod[8] = rnd30(66'(r_w * r_z));
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    // Matrix entries from the rounded terms, saturated.
    always_comb begin
        logic signed [37:0] one;
        logic signed [37:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
        one = 38'sd1073741824;
        xx = 38'($signed(r_prod[0])); yy = 38'($signed(r_prod[1]));
        zz = 38'($signed(r_prod[2])); xy = 38'($signed(r_prod[3]));
        xz = 38'($signed(r_prod[4])); yz = 38'($signed(r_prod[5]));
        wx = 38'($signed(r_prod[6])); wy = 38'($signed(r_prod[7]));
        wz = 38'($signed(r_prod[8]));
        n_mat[0] = sat32(one - 2 * (yy + zz));
        n_mat[1] = sat32(2 * (xy - wz));
        n_mat[2] = sat32(2 * (xz + wy));
        n_mat[3] = sat32(2 * (xy + wz));
        n_mat[4] = sat32(one - 2 * (xx + zz));
        n_mat[5] = sat32(2 * (yz - wx));
        n_mat[6] = sat32(2 * (xz - wy));
        n_mat[7] = sat32(2 * (yz + wx));
        n_mat[8] = sat32(one - 2 * (xx + yy));
    end

    always_ff @(posedge i_clk) begin
        r_mat <= n_mat;
    end

    assign o_mat   = r_mat;
    assign o_shift = r_shift;

endmodule

>>> rtl/rt3d_lane.sv
// ============================================================================
// rt3d_lane: one corner mapper
// Maps one vector by R or R transposed in three stages: translate, multiply,
// sum and saturate.
// ============================================================================
module rt3d_lane (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  rt3d_pkg::t_matrix         i_mat,
    input  logic signed [2:0][31:0]   i_shift,
    input  rt3d_pkg::t_ctl            i_ctl,
    input  logic signed [2:0][31:0]   i_vec,
    output logic signed [2:0][31:0]   o_res
);
    import rt3d_pkg::*;

    logic signed [2:0][32:0] r_u;
    logic signed [2:0][32:0] n_u;
    logic [1:0] r_wp;
    logic signed [8:0][35:0] r_prod;
    logic signed [8:0][35:0] n_prod;
    logic signed [2:0][31:0] r_res;
    logic signed [2:0][31:0] n_res;

    // Stage 1: subtract the translation for point to local.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (i_ctl.point && !i_ctl.world) begin
                n_u[i] = 33'($signed(i_vec[i])) - 33'($signed(i_shift[i]));
            end else begin
                n_u[i] = 33'($signed(i_vec[i]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u  <= n_u;
            r_wp <= {i_ctl.world, i_ctl.point};
        end
    end

    // Stage 2: nine rounded products, rows of R or of R transposed.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                logic signed [31:0] e;
                e = r_wp[1] ? i_mat[i*3+j] : i_mat[j*3+i];
                n_prod[i*3+j] = rnd30(66'(e * $signed(r_u[j])));
            end
        end
    end

    logic [1:0] r_wp2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_wp2  <= r_wp;
        end
    end

    // Stage 3: exact sum, translation for point to world, one saturation.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [37:0] acc;
            acc = 38'($signed(r_prod[i*3])) + 38'($signed(r_prod[i*3+1])) +
                  38'($signed(r_prod[i*3+2]));
            if (r_wp2[1] && r_wp2[0]) begin
                acc = acc + 38'($signed(i_shift[i]));
            end
            n_res[i] = sat32(acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

>>> rtl/rt3d_merge.sv
// ============================================================================
// rt3d_merge: corner merge
// Merges the eight lane results into box bounds, passes lane zero, or gives 0.
// ============================================================================
module rt3d_merge (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  rt3d_pkg::t_ctl                  i_ctl,
    input  logic signed [7:0][2:0][31:0]    i_res,
    output rt3d_pkg::t_out_item             o_item
);
    import rt3d_pkg::*;

    logic signed [3:0][2:0][31:0] r_lo4, r_hi4;
    logic signed [3:0][2:0][31:0] n_lo4, n_hi4;
    t_ctl r_ctl;
    t_out_item r_item;
    t_out_item n_item;

    // First level: pairwise min and max of the eight corners.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [31:0] a, b;
                a = i_res[2*k][i];
                b = i_res[2*k+1][i];
                n_lo4[k][i] = (b < a) ? b : a;
                n_hi4[k][i] = (b > a) ? b : a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo4 <= n_lo4;
            r_hi4 <= n_hi4;
            r_ctl <= i_ctl;
        end
    end

    // Remaining levels and output select.
    always_comb begin
        logic signed [2:0][31:0] lo, hi;
        for (int i = 0; i < 3; i++) begin
            logic signed [31:0] l0, l1, h0, h1;
            l0 = ($signed(r_lo4[1][i]) < $signed(r_lo4[0][i])) ? r_lo4[1][i] : r_lo4[0][i];
            l1 = ($signed(r_lo4[3][i]) < $signed(r_lo4[2][i])) ? r_lo4[3][i] : r_lo4[2][i];
            h0 = ($signed(r_hi4[1][i]) > $signed(r_hi4[0][i])) ? r_hi4[1][i] : r_hi4[0][i];
            h1 = ($signed(r_hi4[3][i]) > $signed(r_hi4[2][i])) ? r_hi4[3][i] : r_hi4[2][i];
            lo[i] = (l1 < l0) ? l1 : l0;
            hi[i] = (h1 > h0) ? h1 : h0;
        end
        n_item = '0;
        if (r_ctl.zero) begin
            n_item = '0;
        end else if (r_ctl.box) begin
            n_item.rx = lo[0]; n_item.ry = lo[1]; n_item.rz = lo[2];
            n_item.sx = hi[0]; n_item.sy = hi[1]; n_item.sz = hi[2];
        end else begin
            // lane zero holds the unpaired vector; its min is that vector
            n_item.rx = r_lo4[0][0];
            n_item.ry = r_lo4[0][1];
            n_item.rz = r_lo4[0][2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

>>> rtl/rigid_transform_3d_unit.sv
// ============================================================================
// rigid_transform_3d_unit: 3D rigid transform by quaternion and translation
// Maps points, directions and axis-aligned boxes between local and world frame.
// ============================================================================
// One item is accepted per cycle unless the pipe stalls; its result passes the
// input register, three lane stages, two merge stages and the output register;
// eight lanes map the eight box corners at once, so boxes run at the same rate as
// points. Every stage advances together when the output register is free or
// being taken. A register write reaches the matrix via the product register.
module rigid_transform_3d_unit #(
    parameter int FRAC_BITS = rt3d_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  rt3d_pkg::t_in_item              i_item,
    output logic                            o_valid,
    input  logic                            i_stall,
    output rt3d_pkg::t_out_item             o_item,
    input  logic                            i_cfg_we,
    input  logic [rt3d_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rt3d_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rt3d_pkg::*;

    localparam int LAT = 7;
    // Coordinates keep their format, so the fraction width only bounds the range.
    localparam bit FRAC_OK = (FRAC_BITS >= 8) && (FRAC_BITS <= 24);

    t_matrix mat;
    logic signed [2:0][31:0] shift;
    logic signed [7:0][2:0][31:0] lane_res;
    logic [LAT-1:0] r_vld;
    logic advance;
    t_out_item merged;
    t_out_item r_out;

    // Pipeline state per stage: control, and the captured item.
    t_in_item r_in;
    t_ctl r_ctl0;
    t_ctl r_ctl1, r_ctl2, r_ctl3;

    rt3d_matrix u_matrix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_mat      (mat),
        .o_shift    (shift)
    );

    // A stall holds the whole pipe; valid bits drop as data leaves.
    assign advance = !(o_valid && i_stall);
    assign o_stall = !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= {r_vld[LAT-2:0], i_valid && FRAC_OK};
        end
    end

    // Input register and decoded control.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_in <= i_item;
            r_ctl0.world <= i_item.mode[0];
            r_ctl0.point <= (i_item.mode == MODE_PT_LOCAL) ||
                            (i_item.mode == MODE_PT_WORLD) ||
                            (i_item.mode == MODE_BOX_LOCAL) ||
                            (i_item.mode == MODE_BOX_WORLD);
            r_ctl0.box   <= (i_item.mode == MODE_BOX_LOCAL) ||
                            (i_item.mode == MODE_BOX_WORLD);
            r_ctl0.zero  <= (i_item.mode != MODE_PT_LOCAL) &&
                            (i_item.mode != MODE_PT_WORLD) &&
                            (i_item.mode != MODE_DIR_LOCAL) &&
                            (i_item.mode != MODE_DIR_WORLD) &&
                            (i_item.mode != MODE_BOX_LOCAL) &&
                            (i_item.mode != MODE_BOX_WORLD);
            r_ctl1 <= r_ctl0;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
        end
    end

    // Eight corner lanes; outside box modes every lane sees vector a.
    for (genvar k = 0; k < 8; k++) begin : g_lane
        logic signed [2:0][31:0] corner;
        logic signed [2:0][31:0] lane_q;
        assign corner[0] = (r_ctl0.box && ((k & 1) != 0)) ? r_in.bx : r_in.ax;
        assign corner[1] = (r_ctl0.box && ((k & 2) != 0)) ? r_in.by : r_in.ay;
        assign corner[2] = (r_ctl0.box && ((k & 4) != 0)) ? r_in.bz : r_in.az;
        rt3d_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (advance),
            .i_mat   (mat),
            .i_shift (shift),
            .i_ctl   (r_ctl0),
            .i_vec   (corner),
            .o_res   (lane_q)
        );
        assign lane_res[k] = lane_q;
    end

    rt3d_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (advance),
        .i_ctl  (r_ctl3),
        .i_res  (lane_res),
        .o_item (merged)
    );

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= merged;
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_item  = r_out;

endmodule

>>> dv/rigid_transform_3d_unit_tb.sv
// ============================================================================
// rigid_transform_3d_unit_tb: self-checking bench of the rigid transform unit
// A directed table of modes and extremes runs first, then odd rotations,
// random points, directions and boxes under several rotation and translation
// settings; checks use typed results or a behavioral fixed-point predictor.
// ============================================================================
module rigid_transform_3d_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rt3d_pkg::*;

    localparam int  LATENCY  = 7;
    localparam logic signed [31:0] ONE30 = 32'sh40000000;
    localparam logic signed [31:0] MAXV  = 32'sh7fffffff;
    localparam logic signed [31:0] MINV  = 32'sh80000000;
    localparam logic [2:0] MODE_UNUSED6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED7 = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in_item    i_item = '0;
    logic        o_valid;
    logic        i_stall = 1'b1;
    t_out_item   o_item;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    rigid_transform_3d_unit i_dut (.*);

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bench copy of the configuration registers.
    logic signed [31:0] q_w = ONE30, q_x = '0, q_y = '0, q_z = '0;
    logic signed [31:0] t_x = '0, t_y = '0, t_z = '0;

    t_out_item expected_q[$];
    int  err_count = 0;
    bit  long_hold = 0;

    // Stimulus table entry: item, whether an expected result is typed in.
    typedef struct {
        t_in_item  item;
        bit        fixed;
        t_out_item res;
    } t_row;

    function automatic longint round30(input longint a, input longint b);
        longint p;
        p = a * b + (longint'(1) <<< 29);
        return p >>> 30;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Rotate (and translate) one vector with the current configuration.
    function automatic void transform_vec(input longint mat[9], input longint v[3],
                                          input bit world, input bit point,
                                          output longint r[3]);
        longint t[3];
        longint u[3];
        longint acc;
        t = '{longint'(t_x), longint'(t_y), longint'(t_z)};
        for (int i = 0; i < 3; i++) u[i] = (point && !world) ? v[i] - t[i] : v[i];
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += round30(world ? mat[i*3+j] : mat[j*3+i], u[j]);
            if (point && world) acc += t[i];
            r[i] = clamp32(acc);
        end
    endfunction

    function automatic t_out_item transform_item(input t_in_item it);
        longint one, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint mat[9];
        longint a[3], b[3], c[3], r[3], lo[3], hi[3];
        t_out_item o;
        one = longint'(1) <<< 30;
        xx = round30(q_x, q_x); yy = round30(q_y, q_y); zz = round30(q_z, q_z);
        xy = round30(q_x, q_y); xz = round30(q_x, q_z); yz = round30(q_y, q_z);
        wx = round30(q_w, q_x); wy = round30(q_w, q_y); wz = round30(q_w, q_z);
        mat[0] = clamp32(one - 2 * (yy + zz));
        mat[1] = clamp32(2 * (xy - wz));
        mat[2] = clamp32(2 * (xz + wy));
        mat[3] = clamp32(2 * (xy + wz));
        mat[4] = clamp32(one - 2 * (xx + zz));
        mat[5] = clamp32(2 * (yz - wx));
        mat[6] = clamp32(2 * (xz - wy));
        mat[7] = clamp32(2 * (yz + wx));
        mat[8] = clamp32(one - 2 * (xx + yy));
        a = '{longint'(it.ax), longint'(it.ay), longint'(it.az)};
        b = '{longint'(it.bx), longint'(it.by), longint'(it.bz)};
        lo = '{0, 0, 0};
        hi = '{0, 0, 0};
        if (it.mode <= MODE_DIR_WORLD) begin
            transform_vec(mat, a, it.mode[0], it.mode < MODE_DIR_LOCAL, lo);
        end else if (it.mode <= MODE_BOX_WORLD) begin
            // All eight corners, then the componentwise bounds.
            for (int k = 0; k < 8; k++) begin
                for (int i = 0; i < 3; i++) c[i] = ((k >> i) & 1) ? b[i] : a[i];
                transform_vec(mat, c, it.mode == MODE_BOX_WORLD, 1'b1, r);
                for (int i = 0; i < 3; i++) begin
                    if (k == 0 || r[i] < lo[i]) lo[i] = r[i];
                    if (k == 0 || r[i] > hi[i]) hi[i] = r[i];
                end
            end
        end
        o.rx = lo[0][31:0]; o.ry = lo[1][31:0]; o.rz = lo[2][31:0];
        o.sx = hi[0][31:0]; o.sy = hi[1][31:0]; o.sz = hi[2][31:0];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what,
                 $signed(got), $signed(want), $realtime);
        err_count++;
    endtask

    // Drives one register write; the caller drops the write enable.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_ROT_W:   q_w = val;
            REG_ROT_X:   q_x = val;
            REG_ROT_Y:   q_y = val;
            REG_ROT_Z:   q_z = val;
            REG_SHIFT_X: t_x = val;
            REG_SHIFT_Y: t_y = val;
            default:     t_z = val;
        endcase
    endtask

    task automatic set_transform(input logic [31:0] w, input logic [31:0] x,
                                 input logic [31:0] y, input logic [31:0] z,
                                 input logic [31:0] sx, input logic [31:0] sy,
                                 input logic [31:0] sz);
        write_reg(REG_ROT_W, w);
        write_reg(REG_ROT_X, x);
        write_reg(REG_ROT_Y, y);
        write_reg(REG_ROT_Z, z);
        write_reg(REG_SHIFT_X, sx);
        write_reg(REG_SHIFT_Y, sy);
        write_reg(REG_SHIFT_Z, sz);
        i_cfg_we <= 1'b0;
        // Let the matrix follow the new registers.
        repeat (3) @(posedge i_clk);
    endtask

    // Offer one transfer after a random gap and wait for its acceptance.
    task automatic send_item(input t_in_item it, input bit fixed, input t_out_item res);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk iff !o_stall);
        expected_q.push_back(fixed ? res : transform_item(it));
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (expected_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 3) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return MAXV;
            1: return MINV;
            2: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
            3: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_quat();
        case ($urandom_range(0, 4))
            0: return ONE30;
            1: return -ONE30;
            2: return 32'sd0;
            default: return $signed($urandom_range(0, 32'h7fffffff)) - ONE30;
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.mode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
        it.ax = rand_coord(); it.ay = rand_coord(); it.az = rand_coord();
        it.bx = rand_coord(); it.by = rand_coord(); it.bz = rand_coord();
        // Mostly well-ordered boxes, some inverted.
        if (it.mode >= MODE_BOX_LOCAL && $urandom_range(0, 3) != 0) begin
            it.bx = it.ax + 32'($urandom_range(0, 32'h00ffffff));
            it.by = it.ay + 32'($urandom_range(0, 32'h00ffffff));
            it.bz = it.az + 32'($urandom_range(0, 32'h00ffffff));
        end
        return it;
    endfunction

    // Receiver: random stalls, plus one long hold-off.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (200) @(posedge i_clk);
                long_hold = 0;
            end
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
            if (gap != 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", o_item.rx, 32'd0);
            end else begin
                want = expected_q.pop_front();
                if (o_item.rx !== want.rx) report_mismatch("rx", o_item.rx, want.rx);
                if (o_item.ry !== want.ry) report_mismatch("ry", o_item.ry, want.ry);
                if (o_item.rz !== want.rz) report_mismatch("rz", o_item.rz, want.rz);
                if (o_item.sx !== want.sx) report_mismatch("sx", o_item.sx, want.sx);
                if (o_item.sy !== want.sy) report_mismatch("sy", o_item.sy, want.sy);
                if (o_item.sz !== want.sz) report_mismatch("sz", o_item.sz, want.sz);
            end
        end
    end

    // Main sequence.
    initial begin
        t_row rows[$];
        t_row r;
        t_out_item z;
        z = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: identity rotation after reset gives the input back.
        r.fixed = 1; r.item = '{MODE_PT_WORLD, MAXV, MINV, 32'sd65536, 0, 0, 0};
        r.res = '{MAXV, MINV, 32'sd65536, 0, 0, 0}; rows.push_back(r);
        r.item = '{MODE_PT_LOCAL, -32'sd1, 32'sd0, 32'sd1, 0, 0, 0};
        r.res = '{-32'sd1, 32'sd0, 32'sd1, 0, 0, 0}; rows.push_back(r);
        r.item = '{MODE_DIR_WORLD, MINV, MAXV, 0, MAXV, MAXV, MAXV};
        r.res = '{MINV, MAXV, 0, 0, 0, 0}; rows.push_back(r);
        r.item = '{MODE_DIR_LOCAL, 5, 6, 7, 0, 0, 0};
        r.res = '{5, 6, 7, 0, 0, 0}; rows.push_back(r);
        r.item = '{MODE_BOX_WORLD, MINV, MINV, MINV, MAXV, MAXV, MAXV};
        r.res = '{MINV, MINV, MINV, MAXV, MAXV, MAXV}; rows.push_back(r);
        // Inverted box still yields min and max.
        r.item = '{MODE_BOX_LOCAL, 10, 20, 30, -10, -20, -30};
        r.res = '{-10, -20, -30, 10, 20, 30}; rows.push_back(r);
        // Unused modes give all zeros.
        r.item = '{MODE_UNUSED6, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV};
        r.res = z; rows.push_back(r);
        r.item = '{MODE_UNUSED7, MINV, MINV, MINV, MINV, MINV, MINV};
        r.res = z; rows.push_back(r);
        foreach (rows[i]) send_item(rows[i].item, rows[i].fixed, rows[i].res);
        drain();

        // Rotation and translation at their extremes, predictor-checked rows.
        set_transform(32'sh2d413ccd, 0, 0, 32'sh2d413ccd, MAXV, MINV, 32'sd65536);
        for (int m = 0; m < 8; m++) begin
            send_item(t_in_item'{3'(m), MAXV, MINV, 32'sd123456, MINV, MAXV, 0}, 0, z);
            send_item(t_in_item'{3'(m), -32'sd65536, 32'sd65536, 0, 32'sd65536,
                                 32'sd131072, 32'sd1}, 0, z);
        end
        drain();
        // Non-unit quaternion, extreme components.
        set_transform(MINV >>> 1, ONE30, -ONE30, ONE30, MINV, MAXV, MINV);
        for (int m = 0; m < 6; m++)
            send_item(t_in_item'{3'(m), 32'sd1000, -32'sd1000, MAXV, 0, 0, 0}, 0, z);
        drain();

        // Random phases with fresh settings; a long receiver hold in one.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0) set_transform(ONE30, 0, 0, 0, 0, 0, 0);
            else set_transform(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                               rand_coord(), rand_coord(), rand_coord());
            if (ph == 3) long_hold = 1;
            for (int n = 0; n < 190; n++) send_item(rand_item(), 0, z);
            drain();
        end

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
